// ----- rtl/spring_force_unit_top_macros.svh -----
// assertion macros for the spring force unit
// used by spring_force_unit_top, no other dependencies
`ifndef SPRING_FORCE_UNIT_TOP_MACROS_SVH
`define SPRING_FORCE_UNIT_TOP_MACROS_SVH

// condition in a cycle implies consequence in the same cycle
`define SFU_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// condition in a cycle implies consequence in the next cycle
`define SFU_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sfu_pkg.sv -----
// shared types and constants for the spring force unit
// no dependencies
package sfu_pkg;

  localparam int unsigned SQ_STEPS  = 34;  // root bits, one per sqrt cell
  localparam int unsigned DIV_STEPS = 33;  // quotient bits, one per divide cell
  localparam int unsigned LANES     = 3;

  localparam logic [1:0] MODE_OTHER  = 2'd0;
  localparam logic [1:0] MODE_ANCHOR = 2'd1;
  localparam logic [1:0] MODE_BUNGEE = 2'd2;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_STIFF    = 3'd1;
  localparam logic [2:0] REG_REST     = 3'd2;
  localparam logic [2:0] REG_ANCHOR_X = 3'd3;
  localparam logic [2:0] REG_ANCHOR_Y = 3'd4;
  localparam logic [2:0] REG_ANCHOR_Z = 3'd5;

  // sideband that travels beside the sqrt cells
  typedef struct packed {
    logic             vld;
    logic [2:0]       neg_d;
    logic [2:0]       nz_d;
    logic [2:0][64:0] p1;
  } sq_side_t;

  // sideband through the multiply stages
  typedef struct packed {
    logic       vld;
    logic [2:0] neg;
    logic       kill;
    logic       applied;
    logic [33:0] len;
  } mid_side_t;

  // sideband that travels beside the divide cells
  typedef struct packed {
    logic        vld;
    logic [2:0]  neg;
    logic [2:0]  ovf;
    logic        kill;
    logic        applied;
    logic [49:0] den;
  } div_side_t;

  typedef struct packed {
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
    logic        applied;
    logic        sat;
  } res_t;

endpackage

// ----- rtl/spring_force_unit_top.sv -----
// spring force unit: throughput one transaction per cycle while in_stall stays low
// the pipe runs through the 34-cell root chain and the 33-cell divide chains
// a two-entry output buffer keeps input flowing while one result waits
// synchronous active-high reset clears valid bits, the buffer count and the registers
// to mode 0, stiffness 1.0, rest length 0 and anchor at the origin
// uses sfu_pkg, sfu_sqrt_cell, sfu_div_cell and spring_force_unit_top_macros.svh
`include "spring_force_unit_top_macros.svh"

module spring_force_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] other_x,
  input  logic signed [31:0] other_y,
  input  logic signed [31:0] other_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic        applied,
  output logic        saturated
);

  // configuration registers
  logic [1:0]  spring_mode;
  logic [31:0] stiffness;
  logic [30:0] rest_length;
  logic [31:0] anchor_x, anchor_y, anchor_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_mode <= sfu_pkg::MODE_OTHER;
      stiffness   <= 32'h0001_0000;
      rest_length <= '0;
      anchor_x    <= '0;
      anchor_y    <= '0;
      anchor_z    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        sfu_pkg::REG_MODE:     spring_mode <= cfg_data[1:0];
        sfu_pkg::REG_STIFF:    stiffness   <= cfg_data;
        sfu_pkg::REG_REST:     rest_length <= cfg_data[30:0];
        sfu_pkg::REG_ANCHOR_X: anchor_x    <= cfg_data;
        sfu_pkg::REG_ANCHOR_Y: anchor_y    <= cfg_data;
        sfu_pkg::REG_ANCHOR_Z: anchor_z    <= cfg_data;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // whole pipe moves together; it freezes only when both buffer slots are held and the head is not taken
  logic [1:0] cnt;
  logic       pop;
  logic       adv;
  logic       push;

  assign out_valid = cnt != 2'd0;
  assign pop       = out_valid && !out_stall;
  assign adv       = (cnt != 2'd2) || pop;
  assign in_stall  = !adv;

  // stage a: separation vector, magnitude and sign per lane
  logic [2:0][31:0] p_in, e_in;
  logic [2:0][32:0] dvec;
  logic [2:0][32:0] absd_n;
  logic             a_vld;
  logic [2:0][32:0] a_absd;
  logic [2:0]       a_neg, a_nz;

  assign p_in[0] = pos_x;
  assign p_in[1] = pos_y;
  assign p_in[2] = pos_z;
  // anchor only in anchor mode; the unused mode code acts as spring to other
  assign e_in[0] = (spring_mode == sfu_pkg::MODE_ANCHOR) ? anchor_x : other_x;
  assign e_in[1] = (spring_mode == sfu_pkg::MODE_ANCHOR) ? anchor_y : other_y;
  assign e_in[2] = (spring_mode == sfu_pkg::MODE_ANCHOR) ? anchor_z : other_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvec[i]   = {p_in[i][31], p_in[i]} - {e_in[i][31], e_in[i]};
      absd_n[i] = dvec[i][32] ? (~dvec[i] + 33'd1) : dvec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_absd[i] <= absd_n[i];
        a_neg[i]  <= dvec[i][32];
        a_nz[i]   <= dvec[i] != 33'd0;
      end
    end
  end

  // stage b: squares and the stiffness product
  logic [2:0][65:0] sq_full;
  logic [2:0][64:0] p1_n;
  logic [2:0][64:0] b_sq;
  sfu_pkg::sq_side_t b_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = a_absd[i] * a_absd[i];
      p1_n[i]    = a_absd[i] * stiffness;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_side <= '0;
    end else if (adv) begin
      b_side.vld   <= a_vld;
      b_side.neg_d <= a_neg;
      b_side.nz_d  <= a_nz;
      b_side.p1    <= p1_n;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_sq[i] <= sq_full[i][64:0];
      end
    end
  end

  // stage c: squared length, then the root chain
  logic [65:0] sum_n;
  logic [65:0] c_sum;
  sfu_pkg::sq_side_t sq_side [sfu_pkg::SQ_STEPS + 1];

  assign sum_n = b_sq[0] + b_sq[1] + b_sq[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_side[0] <= '0;
    end else if (adv) begin
      sq_side[0] <= b_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sum <= sum_n;
    end
  end

  logic [67:0] sq_rad  [sfu_pkg::SQ_STEPS + 1];
  logic [35:0] sq_rem  [sfu_pkg::SQ_STEPS + 1];
  logic [33:0] sq_root [sfu_pkg::SQ_STEPS + 1];

  assign sq_rad[0]  = {2'b00, c_sum};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < sfu_pkg::SQ_STEPS; k++) begin : g_sqrt
    sfu_sqrt_cell u_cell (
      .clk     (clk),
      .en      (adv),
      .rad_in  (sq_rad[k]),
      .rem_in  (sq_rem[k]),
      .root_in (sq_root[k]),
      .rad     (sq_rad[k+1]),
      .rem     (sq_rem[k+1]),
      .root    (sq_root[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_side[k+1] <= '0;
      end else if (adv) begin
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // stage d: extension, slack and zero checks, force signs
  sfu_pkg::sq_side_t sq_tail;
  logic [33:0] len;
  logic [34:0] ext;
  logic        e_neg;
  logic [33:0] abse_n;
  logic        slack;
  logic [2:0]  neg_n;
  sfu_pkg::mid_side_t d_side;
  logic [2:0][64:0]   d_p1;
  logic [33:0]        d_abse;

  assign sq_tail = sq_side[sfu_pkg::SQ_STEPS];
  assign len     = sq_root[sfu_pkg::SQ_STEPS];
  assign ext     = {1'b0, len} - {4'b0000, rest_length};
  assign e_neg   = ext[34];
  assign abse_n  = e_neg ? 34'(~ext + 35'd1) : ext[33:0];
  // bungee stays slack unless stretched past rest length
  assign slack   = (spring_mode == sfu_pkg::MODE_BUNGEE) && (len <= {3'b000, rest_length});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_n[i] = sq_tail.nz_d[i] && (ext != 35'd0) && (sq_tail.neg_d[i] == e_neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_side <= '0;
    end else if (adv) begin
      d_side.vld     <= sq_tail.vld;
      d_side.neg     <= neg_n;
      d_side.kill    <= slack || (len == 34'd0);
      d_side.applied <= !slack;
      d_side.len     <= len;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_p1   <= sq_tail.p1;
      d_abse <= abse_n;
    end
  end

  // stage e: product split over two 17-bit halves of the extension
  logic [2:0][81:0] mlo_n, mhi_n;
  logic [2:0][81:0] e_mlo, e_mhi;
  sfu_pkg::mid_side_t e_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mlo_n[i] = d_p1[i] * d_abse[16:0];
      mhi_n[i] = d_p1[i] * d_abse[33:17];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_side <= '0;
    end else if (adv) begin
      e_side <= d_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_mlo <= mlo_n;
      e_mhi <= mhi_n;
    end
  end

  // stage f: full numerator
  logic [2:0][98:0] num_n;
  logic [2:0][98:0] f_num;
  sfu_pkg::mid_side_t f_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_n[i] = {17'd0, e_mlo[i]} + {e_mhi[i], 17'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_side <= '0;
    end else if (adv) begin
      f_side <= e_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_num <= num_n;
    end
  end

  // stage g: overflow check and divider seed; a quotient past 33 bits saturates
  logic [49:0] den_n;
  logic [2:0]  ovf_n;
  sfu_pkg::div_side_t div_side [sfu_pkg::DIV_STEPS + 1];
  logic [2:0][49:0] g_rem;
  logic [2:0][32:0] g_num;

  assign den_n = {f_side.len, 16'd0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ovf_n[i] = f_num[i][98:33] >= {16'd0, den_n};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_side[0] <= '0;
    end else if (adv) begin
      div_side[0].vld     <= f_side.vld;
      div_side[0].neg     <= f_side.neg;
      div_side[0].ovf     <= ovf_n;
      div_side[0].kill    <= f_side.kill;
      div_side[0].applied <= f_side.applied;
      div_side[0].den     <= den_n;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        g_rem[i] <= f_num[i][82:33];
        g_num[i] <= f_num[i][32:0];
      end
    end
  end

  // divide chains, one lane per component
  logic [49:0] dv_rem [3][sfu_pkg::DIV_STEPS + 1];
  logic [32:0] dv_num [3][sfu_pkg::DIV_STEPS + 1];
  logic [32:0] dv_q   [3][sfu_pkg::DIV_STEPS + 1];

  for (genvar k = 0; k < sfu_pkg::DIV_STEPS; k++) begin : g_dside
    always_ff @(posedge clk) begin
      if (rst) begin
        div_side[k+1] <= '0;
      end else if (adv) begin
        div_side[k+1] <= div_side[k];
      end
    end
  end

  for (genvar ln = 0; ln < sfu_pkg::LANES; ln++) begin : g_lane
    assign dv_rem[ln][0] = g_rem[ln];
    assign dv_num[ln][0] = g_num[ln];
    assign dv_q[ln][0]   = '0;

    for (genvar k = 0; k < sfu_pkg::DIV_STEPS; k++) begin : g_div
      sfu_div_cell u_cell (
        .clk    (clk),
        .en     (adv),
        .den    (div_side[k].den),
        .rem_in (dv_rem[ln][k]),
        .num_in (dv_num[ln][k]),
        .q_in   (dv_q[ln][k]),
        .rem    (dv_rem[ln][k+1]),
        .num    (dv_num[ln][k+1]),
        .q      (dv_q[ln][k+1])
      );
    end
  end

  // result assembly: sign, clipping, slack and zero length
  sfu_pkg::div_side_t dv_tail;
  logic [2:0][31:0]   frc;
  logic [2:0]         clip;
  logic [32:0]        qv;
  logic [32:0]        lim;
  sfu_pkg::res_t      tail_res;

  assign dv_tail = div_side[sfu_pkg::DIV_STEPS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv      = dv_q[i][sfu_pkg::DIV_STEPS];
      lim     = dv_tail.neg[i] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      clip[i] = dv_tail.ovf[i] || (qv > lim);
      if (dv_tail.kill) begin
        frc[i]  = '0;
        clip[i] = 1'b0;
      end else if (clip[i]) begin
        frc[i] = dv_tail.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        frc[i] = dv_tail.neg[i] ? (~qv[31:0] + 32'd1) : qv[31:0];
      end
    end
  end

  assign tail_res.fx      = frc[0];
  assign tail_res.fy      = frc[1];
  assign tail_res.fz      = frc[2];
  assign tail_res.applied = dv_tail.applied;
  assign tail_res.sat     = |clip;
  assign push             = adv && dv_tail.vld;

  // two-entry output buffer: head drives the ports, skid catches one more
  sfu_pkg::res_t hd, sk;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      unique case (cnt)
        2'd0: begin
          if (push) begin
            hd  <= tail_res;
            cnt <= 2'd1;
          end
        end
        2'd1: begin
          if (push && pop) begin
            hd <= tail_res;
          end else if (push) begin
            sk  <= tail_res;
            cnt <= 2'd2;
          end else if (pop) begin
            cnt <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            hd <= sk;
            if (push) begin
              sk <= tail_res;
            end else begin
              cnt <= 2'd1;
            end
          end
        end
        default: cnt <= 2'd0;
      endcase
    end
  end

  assign force_x   = hd.fx;
  assign force_y   = hd.fy;
  assign force_z   = hd.fz;
  assign applied   = hd.applied;
  assign saturated = hd.sat;

  // checks on buffer flow and result consistency
  `SFU_ASSERT_NOW(a_full_stall, clk, rst, (cnt == 2'd2) && out_stall, in_stall, "full buffer must stall input")
  `SFU_ASSERT_NOW(a_sat_applied, clk, rst, out_valid && saturated, applied, "clipped result without force")
  `SFU_ASSERT_NOW(a_slack_zero, clk, rst, out_valid && !applied, (force_x == 32'd0) && (force_y == 32'd0) && (force_z == 32'd0), "slack result carries force")
  `SFU_ASSERT_NEXT(a_hold_count, clk, rst, (cnt == 2'd2) && !pop, cnt == 2'd2, "buffer lost an entry")

endmodule

// ----- rtl/sfu_sqrt_cell.sv -----
// one radix-2 digit step of the integer square root
// no package dependencies, widths are fixed by its ports
module sfu_sqrt_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [67:0] rad_in,
  input  logic [35:0] rem_in,
  input  logic [33:0] root_in,
  output logic [67:0] rad,
  output logic [35:0] rem,
  output logic [33:0] root
);

  logic [37:0] rem_sh;
  logic [37:0] trial;
  logic        ge;
  logic [37:0] diff;

  assign rem_sh = {rem_in, rad_in[67:66]};
  assign trial  = {2'b00, root_in, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rad  <= {rad_in[65:0], 2'b00};
      rem  <= ge ? diff[35:0] : rem_sh[35:0];
      root <= {root_in[32:0], ge};
    end
  end

endmodule

// ----- rtl/sfu_div_cell.sv -----
// one restoring divide step, one quotient bit per cell
// no package dependencies
module sfu_div_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [49:0] den,
  input  logic [49:0] rem_in,
  input  logic [32:0] num_in,
  input  logic [32:0] q_in,
  output logic [49:0] rem,
  output logic [32:0] num,
  output logic [32:0] q
);

  logic [50:0] t;
  logic        ge;
  logic [50:0] diff;

  assign t    = {rem_in, num_in[32]};
  assign ge   = t >= {1'b0, den};
  assign diff = t - {1'b0, den};

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= ge ? diff[49:0] : t[49:0];
      num <= {num_in[31:0], 1'b0};
      q   <= {q_in[31:0], ge};
    end
  end

endmodule

// ----- tb/spring_force_unit_top_tb.sv -----
// self-checking testbench for spring_force_unit_top: directed table, then random streams
// depends on sfu_pkg and the spring_force_unit_top rtl only
module spring_force_unit_top_tb;

  logic        clk;
  logic        rst;
  logic        cfg_wr;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic signed [31:0] pos_x, pos_y, pos_z, other_x, other_y, other_z;
  logic        out_valid;
  logic        out_stall;
  logic signed [31:0] force_x, force_y, force_z;
  logic        applied;
  logic        saturated;

  spring_force_unit_top uut (
    .clk(clk), .rst(rst),
    .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .other_x(other_x), .other_y(other_y), .other_z(other_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .applied(applied), .saturated(saturated)
  );

  // local copy of the register file, tracks every write
  logic [1:0]         spring_mode;
  logic [31:0]        stiffness;
  logic [30:0]        rest_length;
  logic signed [31:0] anchor [3];

  sfu_pkg::res_t force_q [$];  // forces still owed by the block, oldest first
  int   error_count;
  int   items_sent;
  int   forces_seen;
  int   sat_seen;
  int   slack_seen;

  // receiver controls
  bit   recv_quiet;         // no receiver stalls in the closing part
  bit   recv_hold_req;      // ask for one long receiver hold-off
  bit   send_quiet;         // no sender gaps in the closing part

  // one directed stimulus row: config, item and optionally a typed-in result
  typedef struct {
    logic [1:0]         mode;
    logic [31:0]        k;
    logic [30:0]        rest;
    logic signed [31:0] p [3];
    logic signed [31:0] o [3];
    bit                 typed;
    sfu_pkg::res_t      want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // clock, period 10
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #60000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // hooke force for one item under the current register copy
  function automatic sfu_pkg::res_t hooke_force(logic signed [31:0] p [3],
                                                logic signed [31:0] o [3]);
    logic signed [32:0] d [3];
    logic [32:0]        m [3];
    logic signed [31:0] endp;
    logic [67:0]        sumsq;
    logic [33:0]        len;
    logic [33:0]        t;
    logic signed [35:0] e;
    logic [35:0]        me;
    logic [49:0]        den;
    logic [127:0]       num;
    logic [127:0]       q;
    logic [127:0]       lim;
    logic               neg;
    logic [31:0]        f [3];
    sfu_pkg::res_t      r;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      endp = (spring_mode == sfu_pkg::MODE_ANCHOR) ? anchor[i] : o[i];
      d[i] = $signed({p[i][31], p[i]}) - $signed({endp[31], endp});
      m[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      sumsq = sumsq + 68'(m[i]) * 68'(m[i]);
    end
    // bitwise integer square root, 34 result bits
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      t = len | (34'd1 << b);
      if (68'(t) * 68'(t) <= sumsq) len = t;
    end
    r = '0;
    r.applied = 1'b1;
    f[0] = '0; f[1] = '0; f[2] = '0;
    if (spring_mode == sfu_pkg::MODE_BUNGEE && len <= 34'(rest_length)) begin
      r.applied = 1'b0;  // bungee slack
    end else if (len != 0) begin
      e   = $signed({2'b00, len}) - $signed({5'b00000, rest_length});
      me  = e[35] ? 36'(-e) : 36'(e);
      den = {len, 16'h0000};
      for (int i = 0; i < 3; i++) begin
        neg = (d[i] > 0 && e > 0) || (d[i] < 0 && e < 0);
        num = 128'(m[i]) * 128'(stiffness) * 128'(me);
        q   = num / 128'(den);
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
          r.sat = 1'b1;
          f[i] = neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
          f[i] = neg ? -q[31:0] : q[31:0];
        end
      end
    end
    r.fx = f[0];
    r.fy = f[1];
    r.fz = f[2];
    return r;
  endfunction

  // result checker: oldest expectation against each accepted result
  always @(posedge clk) begin
    sfu_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (force_q.size() == 0) begin
        $display("%0t: unexpected result fx=%h fy=%h fz=%h", $time, force_x, force_y, force_z);
        error_count++;
      end else begin
        want = force_q.pop_front();
        forces_seen++;
        if (want.sat) sat_seen++;
        if (!want.applied) slack_seen++;
        if (force_x !== want.fx) begin
          $display("%0t: force_x expected %h actual %h", $time, want.fx, force_x);
          error_count++;
        end
        if (force_y !== want.fy) begin
          $display("%0t: force_y expected %h actual %h", $time, want.fy, force_y);
          error_count++;
        end
        if (force_z !== want.fz) begin
          $display("%0t: force_z expected %h actual %h", $time, want.fz, force_z);
          error_count++;
        end
        if (applied !== want.applied) begin
          $display("%0t: applied expected %b actual %b", $time, want.applied, applied);
          error_count++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
          error_count++;
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request, quiet at the end
  initial begin
    int n;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (recv_hold_req) begin
        // long hold-off so the pipe and output buffer fill and in_stall rises
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        recv_hold_req = 1'b0;
      end else if (recv_quiet) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 14);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 30);
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  // offer one transaction and hold it until accepted, then record its force
  task automatic send_item(logic signed [31:0] p [3], logic signed [31:0] o [3],
                           bit typed, sfu_pkg::res_t want);
    sfu_pkg::res_t exp_r;
    exp_r = typed ? want : hooke_force(p, o);
    in_valid <= 1'b1;
    pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
    other_x <= o[0]; other_y <= o[1]; other_z <= o[2];
    do @(posedge clk); while (in_stall);
    force_q = {force_q, exp_r};
    items_sent++;
  endtask

  // sender gap, its length set by n
  task automatic send_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop offering and wait for every owed force, then let the pipe settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (force_q.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // register write, mirrored into the local copy
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr <= 1'b0;
    case (idx)
      sfu_pkg::REG_MODE:     spring_mode = val[1:0];
      sfu_pkg::REG_STIFF:    stiffness = val;
      sfu_pkg::REG_REST:     rest_length = val[30:0];
      sfu_pkg::REG_ANCHOR_X: anchor[0] = val;
      sfu_pkg::REG_ANCHOR_Y: anchor[1] = val;
      sfu_pkg::REG_ANCHOR_Z: anchor[2] = val;
      default: ;  // index past the list is ignored
    endcase
    @(posedge clk);
  endtask

  task automatic add_row(logic [1:0] mode, logic [31:0] k, logic [30:0] rest,
                         logic signed [31:0] px, logic signed [31:0] py,
                         logic signed [31:0] pz, logic signed [31:0] ox,
                         logic signed [31:0] oy, logic signed [31:0] oz,
                         bit typed, logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                         logic app, logic sat);
    dir_row_t r;
    r.mode = mode; r.k = k; r.rest = rest;
    r.p[0] = px; r.p[1] = py; r.p[2] = pz;
    r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
    r.typed = typed;
    r.want.fx = fx; r.want.fy = fy; r.want.fz = fz;
    r.want.applied = app; r.want.sat = sat;
    dir_rows = {dir_rows, r};
  endtask

  // random signed offset from one of four ranges, small up to full width
  function automatic logic signed [31:0] rand_offset();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 32'h0000_ffff)) - 32'sh0000_8000;
      1: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      2: return $signed($urandom_range(0, 32'h1fff_ffff)) - 32'sh1000_0000;
      default: return $urandom;
    endcase
  endfunction

  // one random item, shaped so most land in the interesting force range
  task automatic random_item;
    logic signed [31:0] p [3];
    logic signed [31:0] o [3];
    logic signed [31:0] b [3];
    int   kind;
    sfu_pkg::res_t none;
    none = '0;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      b[i] = (spring_mode == sfu_pkg::MODE_ANCHOR) ? anchor[i] : $signed($urandom);
      o[i] = (spring_mode == sfu_pkg::MODE_ANCHOR) ? $signed($urandom) : b[i];
    end
    for (int i = 0; i < 3; i++) begin
      case (kind)
        0, 1: begin
          p[i] = $urandom;
          o[i] = $urandom;
        end
        7: p[i] = b[i];  // zero separation
        8: p[i] = (i == 0) ? b[i] + $signed({1'b0, rest_length})
                             + $signed($urandom_range(0, 64)) - 32 : b[i];  // near rest
        9: begin
          p[i] = $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
          if (spring_mode != sfu_pkg::MODE_ANCHOR)
            o[i] = $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
        end
        default: p[i] = b[i] + rand_offset();
      endcase
    end
    send_item(p, o, 1'b0, none);
  endtask

  initial begin
    logic [31:0] k_pick;
    logic [31:0] r_pick;
    logic [31:0] a_pick;
    rst = 1'b1;
    cfg_wr = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    other_x = '0; other_y = '0; other_z = '0;
    error_count = 0; items_sent = 0; forces_seen = 0; sat_seen = 0; slack_seen = 0;
    recv_quiet = 1'b0; recv_hold_req = 1'b0; send_quiet = 1'b0;
    // register copy starts at reset values
    spring_mode = sfu_pkg::MODE_OTHER; stiffness = 32'h0001_0000; rest_length = '0;
    anchor[0] = '0; anchor[1] = '0; anchor[2] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: mode, stiffness, rest, pos, other, typed result
    // right after reset, zero separation gives no force but counts as applied
    add_row(sfu_pkg::MODE_OTHER, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0,
            1, 0, 0, 0, 1, 0);
    // unit stretch along one axis with unit stiffness pulls back by one
    add_row(sfu_pkg::MODE_OTHER, 32'h0001_0000, 0, 32'sh0001_0000, 0, 0, 0, 0, 0,
            1, 32'hffff_0000, 0, 0, 1, 0);
    add_row(sfu_pkg::MODE_OTHER, 32'h0001_0000, 0, 0, -32'sh0001_0000, 0, 0, 0, 0,
            1, 0, 32'h0001_0000, 0, 1, 0);
    // widest separations clip to the rails
    add_row(sfu_pkg::MODE_OTHER, 32'h0001_0000, 0, 32'sh7fff_ffff, 0, 0,
            32'sh8000_0000, 0, 0, 1, 32'h8000_0000, 0, 0, 1, 1);
    add_row(sfu_pkg::MODE_OTHER, 32'h0001_0000, 0, 32'sh8000_0000, 0, 0,
            32'sh7fff_ffff, 0, 0, 1, 32'h7fff_ffff, 0, 0, 1, 1);
    add_row(sfu_pkg::MODE_OTHER, 32'h0001_0000, 0, 32'sh7fff_ffff, 32'sh8000_0000,
            32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
            0, 0, 0, 0, 0, 0);
    // zero stiffness gives no force
    add_row(sfu_pkg::MODE_OTHER, 32'h0000_0000, 0, 32'sh0123_4567, 0, -32'sh0000_0042,
            0, 0, 0, 1, 0, 0, 0, 1, 0);
    // compressed spring pushes outward, full stiffness
    add_row(sfu_pkg::MODE_OTHER, 32'hffff_ffff, 31'h7fff_ffff, 32'sh0000_1000,
            32'sh0000_2000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(sfu_pkg::MODE_OTHER, 32'hffff_ffff, 31'h0003_0000, 32'sh0001_0000,
            32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // anchor at the origin, other endpoint ignored
    add_row(sfu_pkg::MODE_ANCHOR, 32'h0001_0000, 0, 0, 0, 32'sh0001_0000,
            32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1, 0, 0, 32'hffff_0000, 1, 0);
    add_row(sfu_pkg::MODE_ANCHOR, 32'h0001_0000, 0, 0, 0, 0, 32'sh1234_5678,
            32'sh8765_4321, 5, 1, 0, 0, 0, 1, 0);
    add_row(sfu_pkg::MODE_ANCHOR, 32'h0002_8000, 31'h0000_8000, 32'sh8000_0000,
            32'sh7fff_ffff, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // bungee: slack when not stretched past rest, and at zero separation
    add_row(sfu_pkg::MODE_BUNGEE, 32'h0001_0000, 31'h7fff_ffff, 32'sh0001_0000, 0, 0,
            0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(sfu_pkg::MODE_BUNGEE, 32'h0001_0000, 0, 32'sh0000_7777, 32'sh0000_7777,
            32'sh0000_7777, 32'sh0000_7777, 32'sh0000_7777, 32'sh0000_7777,
            1, 0, 0, 0, 0, 0);
    add_row(sfu_pkg::MODE_BUNGEE, 32'h0001_0000, 0, 32'sh0004_0000, -32'sh0003_0000, 0,
            0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(sfu_pkg::MODE_BUNGEE, 32'h0003_0000, 31'h0002_0000, 32'sh0002_0001, 0, 0,
            0, 0, 0, 0, 0, 0, 0, 0, 0);
    // unused mode value behaves like spring to other
    add_row(2'd3, 32'h0001_0000, 31'h0001_0000, 32'sh0003_0000, 32'sh0004_0000, 0,
            0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(2'd3, 32'hffff_ffff, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
            -32'sh7fff_ffff, 0, 32'sh8000_0000, 0, 0, 0, 0, 0, 0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != spring_mode || dir_rows[i].k != stiffness ||
          dir_rows[i].rest != rest_length) begin
        // registers change only with the pipe empty
        drain();
        write_reg(sfu_pkg::REG_MODE, {30'h0, dir_rows[i].mode});
        write_reg(sfu_pkg::REG_STIFF, dir_rows[i].k);
        write_reg(sfu_pkg::REG_REST, {1'b0, dir_rows[i].rest});
      end
      send_item(dir_rows[i].p, dir_rows[i].o, dir_rows[i].typed, dir_rows[i].want);
      if ($urandom_range(0, 2) == 0) send_gap($urandom_range(1, 14));
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: k_pick = 32'h0001_0000;
        1: k_pick = $urandom_range(0, 32'h000f_ffff);
        2: k_pick = (ph == 2) ? 32'hffff_ffff : 32'h0000_0000;
        default: k_pick = $urandom;
      endcase
      case (ph % 3)
        0: r_pick = 0;
        1: r_pick = $urandom_range(0, 32'h00ff_ffff);
        default: r_pick = (ph == 5) ? 32'h7fff_ffff : $urandom;
      endcase
      write_reg(sfu_pkg::REG_MODE, 32'(ph % 4));
      write_reg(sfu_pkg::REG_STIFF, k_pick);
      write_reg(sfu_pkg::REG_REST, r_pick | ($urandom_range(0, 1) << 31));  // top bit masked off
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(0, 3))
          0: a_pick = 32'h7fff_ffff;
          1: a_pick = 32'h8000_0000;
          default: a_pick = $urandom;
        endcase
        write_reg(sfu_pkg::REG_ANCHOR_X + 3'(a), a_pick);
      end
      // indexes past the list must not disturb anything
      write_reg(3'd6, $urandom);
      write_reg(3'd7, $urandom);
      if (ph == 2) recv_hold_req = 1'b1;  // sender keeps streaming into a held receiver
      if (ph == 7) begin
        recv_quiet = 1'b1;
        send_quiet = 1'b1;
      end
      for (int n = 0; n < 100; n++) begin
        random_item();
        if (!send_quiet && !recv_hold_req && $urandom_range(0, 5) == 0)
          send_gap($urandom_range(1, 14));
      end
    end

    drain();
    $display("covered %0d transactions across all four mode codes, %0d results checked",
             items_sent, forces_seen);
    $display("  including %0d saturated and %0d slack results", sat_seen, slack_seen);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
